[src/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, codes and the entry type of the sorted cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int VALUE_BITS    = 32;
    localparam int OCC_BITS      = 5;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    // Command broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic                     head_le;
        logic [VALUE_BITS-1:0]    value;
        logic [PRIORITY_BITS-1:0] prio;
    } cell_cmd_t;

endpackage

[src/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted queue cell
// Holds one entry; on enqueue it keeps, takes the new entry or takes its left
// neighbor's entry, on dequeue it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_mark,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               mark
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // A marked cell sits at or after the insertion point of the new entry.
    assign mark  = !entry_reg.valid || cmd.head_le || (entry_reg.prio > cmd.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.enq && mark) begin
            if (!left_mark) begin
                entry_next.valid = 1'b1;
                entry_next.value = cmd.value;
                entry_next.prio  = cmd.prio;
            end else begin
                entry_next = left_entry;
            end
        end else if (cmd.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg.value <= entry_next.value;
        entry_reg.prio  <= entry_next.prio;
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
    end

endmodule

[src/sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Up to 16 (value, priority) entries kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel is one operation, selected by
// s_tuser (0 enqueue, 1 dequeue). An enqueue places the entry so that the
// smallest priority number sits at the head; a priority not above the head's
// becomes the new head. A dequeue removes the head.
// Every operation yields exactly one transfer on the m_ channel carrying the
// dequeued value (0 otherwise), the status in m_tuser (ok, empty, full) and
// the occupancy after the operation.
// The result is registered. One operation is taken per cycle unless the
// receiver stalls: every cell compares against the broadcast priority and
// shifts in the same cycle, and the single result register sets the pace.
// If the receiver stalls, the result register holds and s_tready goes low
// until that result is taken; the next input is accepted in the same cycle
// the held result leaves.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] item_value, [39:32] item_priority
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_value, [36:32] occupancy, rest 0
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int N = spq_pkg::CAPACITY;

    spq_pkg::entry_t    ent  [N];
    logic               mark [N];
    spq_pkg::cell_cmd_t cmd;

    logic                              accept;
    logic                              is_deq;
    logic [spq_pkg::OCC_BITS-1:0]      count_reg;
    logic [spq_pkg::OCC_BITS-1:0]      count_next;
    logic                              full;
    logic                              empty;
    logic                              m_valid_reg;
    logic [spq_pkg::VALUE_BITS-1:0]    out_value_reg;
    logic [spq_pkg::VALUE_BITS-1:0]    out_value_next;
    spq_pkg::status_t                  status_reg;
    spq_pkg::status_t                  status_next;
    logic [spq_pkg::OCC_BITS-1:0]      occ_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (spq_pkg::op_t'(s_tuser) == spq_pkg::OP_DEQUEUE);
    assign full     = (count_reg == spq_pkg::OCC_BITS'(N));
    assign empty    = (count_reg == '0);

    always_comb begin
        cmd.enq     = accept && !is_deq && !full;
        cmd.deq     = accept && is_deq && !empty;
        cmd.value   = s_tdata[spq_pkg::VALUE_BITS-1:0];
        cmd.prio    = s_tdata[spq_pkg::VALUE_BITS +: spq_pkg::PRIORITY_BITS];
        cmd.head_le = ent[0].valid && (cmd.prio <= ent[0].prio);
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_m;

            if (gi == 0) begin : g_first
                assign left_e = '0;
                assign left_m = 1'b0;
            end else begin : g_mid
                assign left_e = ent[gi-1];
                assign left_m = mark[gi-1];
            end

            if (gi == N - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = ent[gi+1];
            end

            spq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_mark   (left_m),
                .right_entry (right_e),
                .entry       (ent[gi]),
                .mark        (mark[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next     = count_reg;
        out_value_next = '0;
        status_next    = spq_pkg::ST_OK;
        if (is_deq) begin
            if (empty) begin
                status_next = spq_pkg::ST_EMPTY;
            end else begin
                out_value_next = ent[0].value;
                count_next     = count_reg - 1'b1;
            end
        end else begin
            if (full) begin
                status_next = spq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            occ_reg       <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, occ_reg, out_value_reg};
    assign m_tuser  = status_reg;

endmodule

[tb/tb_sorted_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives enqueue and dequeue transfers with random gaps and back-pressure,
// mirrors the sorted store in a scoreboard and checks every result transfer
// (value, status, occupancy) in order against the mirror's prediction.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_unit;

    typedef struct {
        logic [spq_pkg::VALUE_BITS-1:0] value;
        spq_pkg::status_t               status;
        logic [spq_pkg::OCC_BITS-1:0]   occupancy;
    } queue_result_t;

    // Mirror of the sorted store; each accepted operation queues one result.
    class queue_mirror;
        logic [spq_pkg::VALUE_BITS-1:0]    entry_values[spq_pkg::CAPACITY];
        logic [spq_pkg::PRIORITY_BITS-1:0] entry_prios[spq_pkg::CAPACITY];
        int                                entry_count = 0;
        queue_result_t                     pending_results[$];
        int                                errors = 0;
        int                                n_ops = 0;
        int                                n_checked = 0;
        int                                n_full = 0;
        int                                n_empty = 0;

        function void apply_op(spq_pkg::op_t op, logic [spq_pkg::VALUE_BITS-1:0] value,
                               logic [spq_pkg::PRIORITY_BITS-1:0] prio);
            queue_result_t res;
            int            pos;
            res.value  = '0;
            res.status = spq_pkg::ST_OK;
            n_ops++;
            if (op == spq_pkg::OP_ENQUEUE) begin
                if (entry_count >= spq_pkg::CAPACITY) begin
                    res.status = spq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    // A tie with the head goes in front; other ties go behind.
                    pos = entry_count;
                    if (entry_count == 0 || prio <= entry_prios[0]) begin
                        pos = 0;
                    end else begin
                        for (int i = 1; i < entry_count; i++) begin
                            if (entry_prios[i] > prio) begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    for (int i = entry_count; i > pos; i--) begin
                        entry_values[i] = entry_values[i-1];
                        entry_prios[i]  = entry_prios[i-1];
                    end
                    entry_values[pos] = value;
                    entry_prios[pos]  = prio;
                    entry_count++;
                end
            end else begin
                if (entry_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    res.value = entry_values[0];
                    for (int i = 1; i < entry_count; i++) begin
                        entry_values[i-1] = entry_values[i];
                        entry_prios[i-1]  = entry_prios[i];
                    end
                    entry_count--;
                end
            end
            res.occupancy = entry_count[spq_pkg::OCC_BITS-1:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [spq_pkg::VALUE_BITS-1:0] value,
                                   logic [1:0] status,
                                   logic [spq_pkg::OCC_BITS-1:0] occupancy);
            queue_result_t exp_res;
            if (pending_results.size() == 0) begin
                $error("result transfer with no operation outstanding: value %h", value);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            n_checked++;
            if (value !== exp_res.value) begin
                $error("out_value: expected %h, got %h", exp_res.value, value);
                errors++;
            end
            if (status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, status);
                errors++;
            end
            if (occupancy !== exp_res.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp_res.occupancy, occupancy);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // [31:0] item_value, [39:32] item_priority
    logic        s_tuser = 1'b0;  // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] out_value, [36:32] occupancy
    logic [1:0]  m_tuser;         // [1:0] status

    bit          no_idle = 1'b0;
    queue_mirror mirror = new();

    sorted_priority_queue_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Transfers are seen on both channels at the rising edge; an input is
    // noted before the result check in case a result arrives at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                mirror.apply_op(spq_pkg::op_t'(s_tuser), s_tdata[31:0], s_tdata[39:32]);
            end
            if (m_tvalid && m_tready) begin
                mirror.check_result(m_tdata[31:0], m_tuser, m_tdata[36:32]);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    // Called just after a falling edge; returns just after a falling edge, once the operation has been accepted.
    task automatic send_op(spq_pkg::op_t op, logic [spq_pkg::VALUE_BITS-1:0] value,
                           logic [spq_pkg::PRIORITY_BITS-1:0] prio);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 26) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 40'({$urandom, $urandom});
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, value};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [spq_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [spq_pkg::PRIORITY_BITS-1:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
            return 8'($urandom_range(0, 3));    // dense ties
        end else if (roll < 4) begin
            return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int enq_bias;
        int guard;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dequeue, field extremes, ties with and below the head.
        send_op(spq_pkg::OP_DEQUEUE, 32'hdead_beef, 8'h5a);
        send_op(spq_pkg::OP_ENQUEUE, 32'h7fff_ffff, 8'd255);
        send_op(spq_pkg::OP_ENQUEUE, 32'h8000_0000, 8'd0);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0000, 8'd0);
        send_op(spq_pkg::OP_ENQUEUE, 32'hffff_ffff, 8'd128);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0005, 8'd128);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0006, 8'd255);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0007, 8'd1);
        repeat (7) send_op(spq_pkg::OP_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));
        send_op(spq_pkg::OP_DEQUEUE, 32'hffff_ffff, 8'hff);

        // Random: runs that lean toward filling, draining or balance, so the
        // store is driven into both the full and the empty corner repeatedly.
        enq_bias = 50;
        for (int n = 0; n < 1000; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_bias = 85;
                    1:       enq_bias = 15;
                    default: enq_bias = 50;
                endcase
            end
            no_idle = (n >= 400 && n < 550);
            if ($urandom_range(0, 99) < enq_bias) begin
                send_op(spq_pkg::OP_ENQUEUE, pick_value(), pick_prio());
            end else begin
                send_op(spq_pkg::OP_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        guard = 0;
        while (mirror.pending_results.size() != 0 && guard < 1000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
        if (mirror.pending_results.size() != 0) begin
            $error("%0d results never arrived", mirror.pending_results.size());
            mirror.errors++;
        end

        $display("Ran %0d operations with %0d results checked,", mirror.n_ops,
                 mirror.n_checked);
        $display("including %0d enqueues refused at full and %0d dequeues on empty.",
                 mirror.n_full, mirror.n_empty);
        if (mirror.errors == 0) begin
            $display("tb_sorted_priority_queue_unit: clean");
        end else begin
            $display("tb_sorted_priority_queue_unit: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_sorted_priority_queue_unit: errors");
        $finish;
    end

endmodule
